/* rtl/s256_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types and constants for the hasher core, its round unit and the top.
// ----------------------------------------------------------------------------
package s256_pkg;

  // One 32-bit word of state or schedule.
  typedef logic [31:0] word_t;

  // Round variables a..h, element 0 is a.
  typedef word_t [7:0] vars_t;

  // Width of the message byte count (wraps, bit length is count times eight).
  localparam int unsigned CountW = 61;

  // Commands from the top-level sequencer to the hash core.
  typedef struct packed {
    logic       byte_en;    // shift one byte into the block buffer
    logic [7:0] data_byte;  // byte to shift in
    logic       start;      // begin the 64 rounds on the full block
    logic       hash_init;  // reload the initial hash value
    logic [2:0] rd_idx;     // hash word to read out
  } core_ctrl_t;

  // Status from the hash core.
  typedef struct packed {
    logic busy;  // rounds are running
    logic fold;  // this cycle adds the round variables into the hash
  } core_stat_t;

  // Initial hash value H0..H7.
  localparam word_t InitHash [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants.
  localparam word_t RoundK [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* rtl/s256_round.sv */
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule expansion step. The core
// applies this unit once per cycle for all 64 rounds of a block.
// ----------------------------------------------------------------------------
module s256_round (
  input  s256_pkg::vars_t vars,      // a..h before the round
  input  s256_pkg::word_t k_word,    // round constant
  input  s256_pkg::word_t w_cur,     // W[t]
  input  s256_pkg::word_t w_p1,      // W[t+1]
  input  s256_pkg::word_t w_p9,      // W[t+9]
  input  s256_pkg::word_t w_p14,     // W[t+14]
  output s256_pkg::vars_t vars_next, // a..h after the round
  output s256_pkg::word_t w_new      // W[t+16]
);
  import s256_pkg::*;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  word_t sig0_w;
  word_t sig1_w;
  word_t sum1;
  word_t sum0;
  word_t choose;
  word_t major;
  word_t t1;
  word_t t2;

  // Schedule expansion for the word sixteen rounds ahead.
  always_comb begin
    sig0_w = rotr(w_p1, 7) ^ rotr(w_p1, 18) ^ (w_p1 >> 3);
    sig1_w = rotr(w_p14, 17) ^ rotr(w_p14, 19) ^ (w_p14 >> 10);
    w_new  = sig1_w + w_p9 + sig0_w + w_cur;
  end

  // Compression round.
  always_comb begin
    sum1   = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    sum0   = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1     = vars[7] + sum1 + choose + k_word + w_cur;
    t2     = sum0 + major;
    vars_next[7] = vars[6];
    vars_next[6] = vars[5];
    vars_next[5] = vars[4];
    vars_next[4] = vars[3] + t1;
    vars_next[3] = vars[2];
    vars_next[2] = vars[1];
    vars_next[1] = vars[0];
    vars_next[0] = t1 + t2;
  end

endmodule

/* rtl/s256_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 hash core
// Holds the block buffer, the round variables and the hash value. Bytes shift
// into the buffer; a start command runs 64 rounds, one per cycle, through the
// round unit, then one cycle folds the variables into the hash.
// ----------------------------------------------------------------------------
module s256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  s256_pkg::core_ctrl_t  ctrl,
  output s256_pkg::core_stat_t  stat,
  output s256_pkg::word_t       rd_word
);
  import s256_pkg::*;

  // Word i of the window sits at bits 511-32*i down; word 0 is the oldest.
  logic [511:0] win;
  vars_t        vars;
  vars_t        vars_next;
  vars_t        hash;
  logic [5:0]   rnd;
  logic         busy;
  logic         fold;
  word_t        w_new;

  s256_round u_round (
    .vars      (vars),
    .k_word    (RoundK[rnd]),
    .w_cur     (win[511:480]),
    .w_p1      (win[479:448]),
    .w_p9      (win[223:192]),
    .w_p14     (win[63:32]),
    .vars_next (vars_next),
    .w_new     (w_new)
  );

  // Block buffer: bytes shift in big-endian, rounds shift the schedule along.
  always_ff @(posedge clk) begin
    if (ctrl.byte_en) begin
      win <= {win[503:0], ctrl.data_byte};
    end else if (busy) begin
      win <= {win[479:0], w_new};
    end
  end

  // Round sequencing and the round variables.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fold <= 1'b0;
      rnd  <= '0;
    end else begin
      fold <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fold <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      vars <= hash;
    end else if (busy) begin
      vars <= vars_next;
    end
  end

  // Hash value: reload at reset and after each digest, accumulate per block.
  always_ff @(posedge clk) begin
    if (rst || ctrl.hash_init) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= InitHash[i];
      end
    end else if (fold) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= hash[i] + vars[i];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.fold = fold;
  assign rd_word   = hash[ctrl.rd_idx];

endmodule

/* rtl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the 256-bit digest as eight words.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one message byte per word in s_tdata. s_tuser
//   says the byte is present; a word with s_tuser low and s_tlast high ends
//   an empty message, one with both low is ignored. s_tlast marks the end.
//   The output channel returns H0..H7 in m_tdata, the index in m_tuser and
//   m_tlast on H7.
// Timing:
//   Bytes go in one per cycle while s_tready is high. Each 64th byte starts a
//   compression (64 rounds of the shared round unit, then one fold) with
//   s_tready low. At the end of a message 9 to 72 padding bytes go in at one
//   per cycle, with one or two compressions, and then the eight digest words
//   leave one per cycle as the receiver takes them.
// Reset and stall:
//   rst clears the sequencer and reloads the initial hash. A stalled receiver
//   holds the current digest word in the output register; the last word may
//   wait there while the next message is already being taken in.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // end_of_msg
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_index
  output logic        m_tlast    // last_word
);
  import s256_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_PAD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]        state;
  logic [5:0]        pos;
  logic [CountW-1:0] count;
  logic              pad_active;
  logic              sent80;
  logic              len_mode;
  logic [2:0]        len_idx;
  logic              done_pad;
  logic [2:0]        out_idx;
  logic              in_take;
  logic              out_load;
  logic [63:0]       len_bits;
  logic [7:0]        pad_byte;
  core_ctrl_t        ctrl;
  core_stat_t        stat;
  word_t             rd_word;

  s256_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .stat    (stat),
    .rd_word (rd_word)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign len_bits = {count, 3'b000};

  // Padding byte: the end marker, zeros up to offset 56, then the bit length.
  always_comb begin
    if (!sent80) begin
      pad_byte = 8'h80;
    end else if (!len_mode && pos != 6'd56) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_bits[{~len_idx, 3'b111} -: 8];
    end
  end

  // Commands to the core.
  always_comb begin
    ctrl.byte_en   = (in_take && s_tuser) || (state == ST_PAD);
    ctrl.data_byte = (state == ST_PAD) ? pad_byte : s_tdata;
    ctrl.start     = ctrl.byte_en && (pos == 6'd63);
    ctrl.hash_init = out_load && (out_idx == 3'd7);
    ctrl.rd_idx    = out_idx;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      count      <= '0;
      pad_active <= 1'b0;
      sent80     <= 1'b0;
      len_mode   <= 1'b0;
      len_idx    <= '0;
      done_pad   <= 1'b0;
      out_idx    <= '0;
    end else begin
      if (ctrl.byte_en) begin
        pos <= pos + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (s_tuser) begin
              count <= count + {{(CountW-1){1'b0}}, 1'b1};
            end
            pad_active <= s_tlast;
            if (ctrl.start) begin
              state <= ST_HASH;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_HASH: begin
          if (stat.fold) begin
            if (done_pad) begin
              state <= ST_OUT;
            end else if (pad_active) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_PAD: begin
          if (!sent80) begin
            sent80 <= 1'b1;
          end else if (len_mode || pos == 6'd56) begin
            len_mode <= 1'b1;
            len_idx  <= len_idx + 3'd1;
            if (len_idx == 3'd7) begin
              done_pad <= 1'b1;
            end
          end
          if (ctrl.start) begin
            state <= ST_HASH;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state      <= ST_IDLE;
              count      <= '0;
              pad_active <= 1'b0;
              sent80     <= 1'b0;
              len_mode   <= 1'b0;
              done_pad   <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= rd_word;
      m_tuser <= out_idx;
      m_tlast <= (out_idx == 3'd7);
    end
  end

`ifndef SYNTHESIS
  // A new block only starts when the byte that fills it is written.
  a_start_on_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> ctrl.byte_en && pos == 6'd63)
    else $error("compression started on a partial block");

  // Input is never taken while the core runs its rounds.
  a_idle_core: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.busy)
    else $error("input ready while rounds are running");

  // The digest is read only on a block boundary.
  a_out_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> pos == 6'd0 && !stat.busy)
    else $error("digest read with a partial block");

  // The length field is complete only after the end marker went in.
  a_pad_order: assert property (@(posedge clk) disable iff (rst)
    done_pad |-> sent80 && len_mode)
    else $error("padding finished out of order");

  // The marked word is always the eighth one.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == 3'd7)
    else $error("last word without index seven");
`endif

endmodule
